// File: hdl/heap_sort_binary_search_table_defines.svh
// Assertion macros shared by the checker of the sorted key table.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HEAP_SORT_BINARY_SEARCH_TABLE_DEFINES_SVH
`define HEAP_SORT_BINARY_SEARCH_TABLE_DEFINES_SVH

// Clocked property, disabled during reset.
`define HSBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A stalled transaction keeps its valid and its payload.
`define HSBST_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  `HSBST_ASSERT(lbl, (vld && !rdy) |=> (vld && $stable(sig)), msg)

`endif

// File: hdl/hsbst_pkg.sv
// Shared types and constants of the sorted key table.
// Used by hsbst_ctrl, the top level, the checker and the testbench; depends on nothing.
package hsbst_pkg;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int KEY_W      = 32;
  localparam int PAY_W      = 32;
  localparam int POS_W      = 6;
  localparam int FUNC_W     = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SD_START,
    ST_SD_CAPN,
    ST_SD_CAPL,
    ST_SD_CAPR,
    ST_SD_SWAP,
    ST_EX_CHK,
    ST_EX_R1,
    ST_EX_R2,
    ST_EX_W2,
    ST_LK_RD,
    ST_LK_CMP,
    ST_RD_CAP,
    ST_RES
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    func_e            func;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [POS_W-1:0] position;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } res_t;

endpackage

// File: hdl/hsbst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module hsbst_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int Words = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [Words];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/hsbst_ctrl.sv
// Sequencer of the sorted key table: load, heapsort, binary search and read,
// all through one key comparator and one RAM port pair. Uses hsbst_pkg.
module hsbst_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  hsbst_pkg::item_t         item_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output hsbst_pkg::res_t          res_o,
  output logic                     wr_en_o,
  output logic [hsbst_pkg::IDX_W-1:0] wr_addr_o,
  output hsbst_pkg::entry_t        wr_data_o,
  output logic                     rd_en_o,
  output logic [hsbst_pkg::IDX_W-1:0] rd_addr_o,
  input  hsbst_pkg::entry_t        rd_data_i
);

  localparam int IW = hsbst_pkg::IDX_W;
  localparam int CW = hsbst_pkg::CNT_W;

  hsbst_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [CW-1:0] node_q, node_d;
  logic [CW-1:0] bld_q, bld_d;
  logic [CW-1:0] sz_q, sz_d;
  logic          build_q, build_d;
  logic          gt_q, gt_d;
  hsbst_pkg::entry_t ent_n_q, ent_n_d;
  hsbst_pkg::entry_t ent_l_q, ent_l_d;
  logic [hsbst_pkg::KEY_W-1:0] sk_q, sk_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] hi_q, hi_d;
  logic [IW-1:0] mid_q, mid_d;
  hsbst_pkg::res_t res_q, res_d;

  // Shared key comparator
  logic [hsbst_pkg::KEY_W-1:0] cmp_a;
  logic cmp_lt, cmp_eq;
  logic lc_ok, rc_ok, sift_fin;
  logic [CW-1:0] eff_cnt, load_cnt;
  logic [IW-1:0] mid_c;

  assign lc_ok = {node_q, 1'b0} <= {1'b0, sz_q};
  assign rc_ok = {node_q, 1'b1} <= {1'b0, sz_q};
  assign mid_c = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  always_comb begin
    unique case (state_q)
      hsbst_pkg::ST_LK_CMP:  cmp_a = sk_q;
      hsbst_pkg::ST_SD_CAPR: cmp_a = gt_q ? ent_l_q.key : ent_n_q.key;
      default:               cmp_a = ent_n_q.key;
    endcase
  end

  assign cmp_lt = cmp_a < rd_data_i.key;
  assign cmp_eq = cmp_a == rd_data_i.key;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    done_d    = done_q;
    node_d    = node_q;
    bld_d     = bld_q;
    sz_d      = sz_q;
    build_d   = build_q;
    gt_d      = gt_q;
    ent_n_d   = ent_n_q;
    ent_l_d   = ent_l_q;
    sk_d      = sk_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    res_d     = res_q;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = ent_n_q;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    sift_fin  = 1'b0;
    eff_cnt   = done_q ? '0 : cnt_q;
    load_cnt  = eff_cnt;

    unique case (state_q)
      hsbst_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.func)
            hsbst_pkg::FUNC_LOAD: begin
              // A load after a finished set opens a new set
              done_d = 1'b0;
              if (eff_cnt < CW'(hsbst_pkg::DEPTH)) begin
                wr_en_o   = 1'b1;
                wr_addr_o = IW'(eff_cnt);
                wr_data_o = '{key: item_i.key, payload: item_i.payload};
                load_cnt  = eff_cnt + CW'(1);
              end
              cnt_d = load_cnt;
              if (item_i.last) begin
                sz_d = load_cnt;
                if (load_cnt < CW'(2)) begin
                  done_d = 1'b1;
                end else begin
                  node_d  = load_cnt >> 1;
                  bld_d   = load_cnt >> 1;
                  build_d = 1'b1;
                  state_d = hsbst_pkg::ST_SD_START;
                end
              end
            end
            hsbst_pkg::FUNC_LOOKUP: begin
              sk_d = item_i.key;
              if (done_q && (cnt_q != '0)) begin
                lo_d    = '0;
                hi_d    = IW'(cnt_q - CW'(1));
                state_d = hsbst_pkg::ST_LK_RD;
              end else begin
                res_d   = '0;
                state_d = hsbst_pkg::ST_RES;
              end
            end
            hsbst_pkg::FUNC_READ: begin
              if (CW'(item_i.position) < cnt_q) begin
                rd_en_o   = 1'b1;
                rd_addr_o = IW'(item_i.position);
                mid_d     = IW'(item_i.position);
                state_d   = hsbst_pkg::ST_RD_CAP;
              end else begin
                res_d   = '0;
                state_d = hsbst_pkg::ST_RES;
              end
            end
            default: begin
            end
          endcase
        end
      end
      hsbst_pkg::ST_RD_CAP: begin
        res_d   = '{found: 1'b1, position: hsbst_pkg::POS_W'(mid_q),
                    key: rd_data_i.key, payload: rd_data_i.payload};
        state_d = hsbst_pkg::ST_RES;
      end
      hsbst_pkg::ST_LK_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = mid_c;
        mid_d     = mid_c;
        state_d   = hsbst_pkg::ST_LK_CMP;
      end
      hsbst_pkg::ST_LK_CMP: begin
        priority if (cmp_eq) begin
          res_d   = '{found: 1'b1, position: hsbst_pkg::POS_W'(mid_q),
                      key: rd_data_i.key, payload: rd_data_i.payload};
          state_d = hsbst_pkg::ST_RES;
        end else if (lo_q == hi_q) begin
          res_d   = '0;
          state_d = hsbst_pkg::ST_RES;
        end else begin
          if (cmp_lt) begin
            hi_d = mid_q;
          end else begin
            lo_d = mid_q + IW'(1);
          end
          state_d = hsbst_pkg::ST_LK_RD;
        end
      end
      hsbst_pkg::ST_RES: begin
        if (res_ready_i) begin
          state_d = hsbst_pkg::ST_IDLE;
        end
      end
      hsbst_pkg::ST_SD_START: begin
        if (lc_ok) begin
          rd_en_o   = 1'b1;
          rd_addr_o = IW'(node_q - CW'(1));
          state_d   = hsbst_pkg::ST_SD_CAPN;
        end else begin
          sift_fin = 1'b1;
        end
      end
      hsbst_pkg::ST_SD_CAPN: begin
        ent_n_d   = rd_data_i;
        rd_en_o   = 1'b1;
        rd_addr_o = IW'({node_q, 1'b0} - {(CW+1){1'b0}} - (CW+1)'(1));
        state_d   = hsbst_pkg::ST_SD_CAPL;
      end
      hsbst_pkg::ST_SD_CAPL: begin
        // Left child arrives; note whether it beats the sinking node
        ent_l_d = rd_data_i;
        gt_d    = cmp_lt;
        if (rc_ok) begin
          rd_en_o   = 1'b1;
          rd_addr_o = IW'({node_q, 1'b0});
        end
        state_d = hsbst_pkg::ST_SD_CAPR;
      end
      hsbst_pkg::ST_SD_CAPR: begin
        // Move the winning child up, then the node down in the next cycle
        priority if (rc_ok && cmp_lt) begin
          wr_en_o   = 1'b1;
          wr_addr_o = IW'(node_q - CW'(1));
          wr_data_o = rd_data_i;
          node_d    = CW'({node_q, 1'b1});
          state_d   = hsbst_pkg::ST_SD_SWAP;
        end else if (gt_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = IW'(node_q - CW'(1));
          wr_data_o = ent_l_q;
          node_d    = CW'({node_q, 1'b0});
          state_d   = hsbst_pkg::ST_SD_SWAP;
        end else begin
          sift_fin = 1'b1;
        end
      end
      hsbst_pkg::ST_SD_SWAP: begin
        wr_en_o   = 1'b1;
        wr_addr_o = IW'(node_q - CW'(1));
        wr_data_o = ent_n_q;
        if (lc_ok) begin
          rd_en_o   = 1'b1;
          rd_addr_o = IW'({node_q, 1'b0} - (CW+1)'(1));
          state_d   = hsbst_pkg::ST_SD_CAPL;
        end else begin
          sift_fin = 1'b1;
        end
      end
      hsbst_pkg::ST_EX_CHK: begin
        if (sz_q > CW'(1)) begin
          rd_en_o   = 1'b1;
          rd_addr_o = '0;
          state_d   = hsbst_pkg::ST_EX_R1;
        end else begin
          done_d  = 1'b1;
          state_d = hsbst_pkg::ST_IDLE;
        end
      end
      hsbst_pkg::ST_EX_R1: begin
        ent_n_d   = rd_data_i;
        rd_en_o   = 1'b1;
        rd_addr_o = IW'(sz_q - CW'(1));
        state_d   = hsbst_pkg::ST_EX_R2;
      end
      hsbst_pkg::ST_EX_R2: begin
        wr_en_o   = 1'b1;
        wr_addr_o = '0;
        wr_data_o = rd_data_i;
        state_d   = hsbst_pkg::ST_EX_W2;
      end
      hsbst_pkg::ST_EX_W2: begin
        // Park the old root past the shrinking heap
        wr_en_o   = 1'b1;
        wr_addr_o = IW'(sz_q - CW'(1));
        wr_data_o = ent_n_q;
        sz_d      = sz_q - CW'(1);
        node_d    = CW'(1);
        build_d   = 1'b0;
        state_d   = hsbst_pkg::ST_SD_START;
      end
      default: begin
        state_d = hsbst_pkg::ST_IDLE;
      end
    endcase

    if (sift_fin) begin
      priority if (!build_q) begin
        state_d = hsbst_pkg::ST_EX_CHK;
      end else if (bld_q == CW'(1)) begin
        state_d = hsbst_pkg::ST_EX_CHK;
      end else begin
        bld_d   = bld_q - CW'(1);
        node_d  = bld_q - CW'(1);
        state_d = hsbst_pkg::ST_SD_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsbst_pkg::ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    bld_q   <= bld_d;
    sz_q    <= sz_d;
    build_q <= build_d;
    gt_q    <= gt_d;
    ent_n_q <= ent_n_d;
    ent_l_q <= ent_l_d;
    sk_q    <= sk_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    res_q   <= res_d;
  end

  assign idle_o      = state_q == hsbst_pkg::ST_IDLE;
  assign res_valid_o = state_q == hsbst_pkg::ST_RES;
  assign res_o       = res_q;

endmodule

// File: hdl/heap_sort_binary_search_table.sv
// Sorted key/payload table of 64 entries. Load transactions (tuser 0) write
// one record each; a load with tlast set then runs an in-place max-heap sort
// into ascending key order: it fetches a node (ST_SD_START, ST_SD_CAPN),
// sinks it level by level (ST_SD_CAPL, ST_SD_CAPR, ST_SD_SWAP) and exchanges
// the root (ST_EX_CHK, ST_EX_R1, ST_EX_R2, ST_EX_W2), with the slave side
// not ready meanwhile. A load after a sorted set starts a new set; loads
// beyond 64 records are dropped. A lookup (tuser 1) binary-searches the
// sorted set with at most 7 probes, each a read (ST_LK_RD) and a compare
// (ST_LK_CMP); a read (tuser 2) returns the entry at a position.
// A miss returns found 0 with all other fields zero; tuser 3 is taken and
// dropped. The rate is set by the single RAM read port (one registered read
// per probe or per heap node) and the one shared key comparator. A finished
// result waits in an output register, so the next transaction is accepted
// while the master side stalls. Depends on hsbst_pkg, hsbst_ctrl, hsbst_ram.
module heap_sort_binary_search_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] key, [63:32] payload, [69:64] position, [71:70] zero
  input  logic [hsbst_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  // [1:0] func
  input  logic [hsbst_pkg::FUNC_W-1:0]       s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [5:0] out_position, [37:6] out_key, [69:38] out_payload, [71:70] zero
  output logic [hsbst_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // [0] found
  output logic [0:0]                         m_axis_tuser_o
);

  localparam int KW = hsbst_pkg::KEY_W;
  localparam int PW = hsbst_pkg::PAY_W;
  localparam int SW = hsbst_pkg::POS_W;

  hsbst_pkg::item_t  item;
  hsbst_pkg::res_t   res;
  hsbst_pkg::res_t   out_q;
  hsbst_pkg::entry_t wr_data, rd_data;
  logic [hsbst_pkg::IDX_W-1:0] wr_addr, rd_addr;
  logic wr_en, rd_en;
  logic idle, res_valid, res_ready;
  logic out_vld_q;
  logic [hsbst_pkg::DEPTH*0+2*(KW+PW)-1:0] rd_raw;

  // Unpack the slave transaction
  assign item.func     = hsbst_pkg::func_e'(s_axis_tuser_i);
  assign item.key      = s_axis_tdata_i[KW-1:0];
  assign item.payload  = s_axis_tdata_i[KW+PW-1:KW];
  assign item.position = s_axis_tdata_i[KW+PW+SW-1:KW+PW];
  assign item.last     = s_axis_tlast_i;

  assign s_axis_tready_o = idle;

  hsbst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i & idle),
    .item_i       (item),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data)
  );

  hsbst_ram #(
    .DATA_W ($bits(hsbst_pkg::entry_t)),
    .ADDR_W (hsbst_pkg::IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw[KW+PW-1:0])
  );

  assign rd_raw[2*(KW+PW)-1:KW+PW] = '0;
  assign rd_data = hsbst_pkg::entry_t'(rd_raw[KW+PW-1:0] | rd_raw[2*(KW+PW)-1:KW+PW]);

  // Output register: take a result whenever the slot is empty or draining
  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.found;
  assign m_axis_tdata_o  = {2'b00, out_q.payload, out_q.key, out_q.position};

endmodule

// File: hdl/hsbst_chk.sv
// Port-level checker for the sorted key table, bound to the top level.
// Uses hsbst_pkg and the assertion macros of the defines header.
`include "heap_sort_binary_search_table_defines.svh"

module hsbst_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [hsbst_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                             s_axis_tlast_i,
  input logic [hsbst_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [hsbst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                       m_axis_tuser_o
);

  logic in_acc;
  logic [hsbst_pkg::OUT_DATA_W:0] m_all;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_all  = {m_axis_tuser_o, m_axis_tdata_o};

  `HSBST_ASSERT_HOLD(a_out_hold, m_axis_tvalid_o, m_axis_tready_i, m_all, "result changed while stalled")
  `HSBST_ASSERT(a_miss_zero, (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0), "miss with nonzero fields")
  `HSBST_ASSERT(a_lookup_busy, (in_acc && (s_axis_tuser_i == hsbst_pkg::FUNC_LOOKUP)) |=> !s_axis_tready_o, "ready right after lookup")
  `HSBST_ASSERT(a_load_quick, (in_acc && (s_axis_tuser_i == hsbst_pkg::FUNC_LOAD) && !s_axis_tlast_i) |=> s_axis_tready_o, "plain load stalled")

endmodule

bind heap_sort_binary_search_table hsbst_chk u_chk (.*);

// File: tb/heap_sort_binary_search_table_tb.sv
// Self-checking testbench for heap_sort_binary_search_table: loads, sorts, lookups and reads.
// Uses hsbst_pkg for widths and function codes. A built-in model of the table predicts each
// response that is not typed in, and random gaps and stalls are placed on both stream sides.
module heap_sort_binary_search_table_tb;
  import hsbst_pkg::*;

  // func 3 is taken and dropped by the block
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam res_t MISS = '0;
  localparam int NUM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [POS_W-1:0]  position;
    logic              last;
  } req_t;

  // One row of the directed part: the request, and a typed-in response where it is obvious
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [POS_W-1:0]  position;
    logic              last;
    logic              typed;
    res_t              exp;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic [FUNC_W-1:0]     s_tuser = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  // Model of the table: entries, fill level and whether the set has been sorted
  logic [KEY_W-1:0] sorted_key [DEPTH];
  logic [PAY_W-1:0] sorted_pay [DEPTH];
  int unsigned      fill_count = 0;
  bit               set_sorted = 1'b0;

  res_t        resp_q [$];     // responses still owed by the block, oldest first
  dir_row_t    dir_rows [$];
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;   // set for stretches with no gaps and no stalls
  int unsigned stall_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  heap_sort_binary_search_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  function automatic void table_swap(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] p;
    k = sorted_key[a];
    p = sorted_pay[a];
    sorted_key[a] = sorted_key[b];
    sorted_pay[a] = sorted_pay[b];
    sorted_key[b] = k;
    sorted_pay[b] = p;
  endfunction

  // Sift down in a 1-based max-heap of n entries held at positions 0..n-1
  function automatic void table_sift(int unsigned node, int unsigned n);
    int unsigned lc;
    int unsigned rc;
    int unsigned nxt;
    logic [KEY_W-1:0] kn;
    logic [KEY_W-1:0] kl;
    while (node >= 1 && 2 * node <= n) begin
      lc = 2 * node;
      rc = lc + 1;
      kn = sorted_key[node-1];
      kl = sorted_key[lc-1];
      if (kl > kn) begin
        if (rc <= n && kl < sorted_key[rc-1]) nxt = rc;
        else nxt = lc;
      end else if (rc <= n && kn < sorted_key[rc-1]) begin
        nxt = rc;
      end else begin
        return;
      end
      table_swap(node - 1, nxt - 1);
      node = nxt;
    end
  endfunction

  function automatic void table_sort(int unsigned n);
    int i;
    for (i = n / 2; i >= 1; i--) table_sift(i, n);
    while (n > 1) begin
      table_swap(0, n - 1);
      table_sift(1, n - 1);
      n--;
    end
  endfunction

  // Apply one request to the model; return 1 and the response if the request produces one
  function automatic bit table_apply(input req_t rq, output res_t rs);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned idx;
    bit hit;
    hit = 1'b0;
    idx = 0;
    rs = MISS;
    case (rq.func)
      FUNC_LOAD: begin
        // a load after a sorted set starts a new set
        if (set_sorted) begin
          fill_count = 0;
          set_sorted = 1'b0;
        end
        // drop loads once the table is full
        if (fill_count < DEPTH) begin
          sorted_key[fill_count] = rq.key;
          sorted_pay[fill_count] = rq.payload;
          fill_count++;
        end
        if (rq.last) begin
          table_sort(fill_count);
          set_sorted = 1'b1;
        end
        return 1'b0;
      end
      FUNC_LOOKUP: begin
        if (set_sorted && fill_count > 0) begin
          lo = 0;
          hi = fill_count - 1;
          forever begin
            mid = (lo + hi) >> 1;
            if (rq.key == sorted_key[mid]) begin
              hit = 1'b1;
              idx = mid;
              break;
            end
            if (lo == hi) break;
            if (rq.key < sorted_key[mid]) hi = mid;
            else lo = mid + 1;
          end
        end
      end
      FUNC_READ: begin
        if (rq.position < fill_count) begin
          hit = 1'b1;
          idx = rq.position;
        end
      end
      default: return 1'b0;
    endcase
    if (hit) begin
      rs.found    = 1'b1;
      rs.position = idx[POS_W-1:0];
      rs.key      = sorted_key[idx];
      rs.payload  = sorted_pay[idx];
    end
    return 1'b1;
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Send one request, wait for its transaction, then record what the block owes for it
  task automatic send_req(input req_t rq, input bit typed, input res_t typed_res);
    int unsigned n;
    res_t pred;
    n = 0;
    if (!quiet && $urandom_range(0, 99) < 30) n = idle_len();
    if (n > 0) begin
      s_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {2'b00, rq.position, rq.payload, rq.key};
    s_tlast <= rq.last;
    s_tuser <= rq.func;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
    if (table_apply(rq, pred)) resp_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %h, actual %h", name, exp, act);
      fail_cnt++;
    end
  endtask

  // Response side: check each transaction against the oldest owed response, then stall at random
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (resp_q.size() == 0) begin
        $error("unexpected result: found %b, tdata %h", m_tuser[0], m_tdata);
        fail_cnt++;
      end else begin
        want = resp_q.pop_front();
        check_field("found", 32'(want.found), 32'(m_tuser[0]));
        check_field("out_position", 32'(want.position), 32'(m_tdata[5:0]));
        check_field("out_key", want.key, m_tdata[37:6]);
        check_field("out_payload", want.payload, m_tdata[69:38]);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  initial begin
    req_t rq;
    req_t noise;
    logic [KEY_W-1:0] set_keys [$];
    logic [KEY_W-1:0] k;
    int unsigned set_size;
    int unsigned lookups;
    int unsigned r;
    bit dup;

    // Directed part: empty table, unused func, extreme keys and payloads, read before
    // completion, hits, misses, out-of-range read and a single-entry new set
    dir_rows.push_back('{FUNC_LOOKUP, 32'h0, 32'h0, 6'd0, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_READ, 32'h0, 32'h0, 6'd0, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, MISS});
    dir_rows.push_back('{FUNC_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0, 6'd5, 1'b0, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOAD, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0, 1'b0, MISS});
    dir_rows.push_back('{FUNC_READ, 32'h0, 32'h0, 6'd0, 1'b0, 1'b1,
                         res_t'{1'b1, 6'd0, 32'hFFFF_FFFF, 32'h0}});
    dir_rows.push_back('{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_LOAD, 32'h0, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOAD, 32'h8000_0000, 32'h1234_5678, 6'd0, 1'b0, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOAD, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 6'd0, 1'b1, 1'b0, MISS});
    dir_rows.push_back('{FUNC_READ, 32'h0, 32'h0, 6'd0, 1'b0, 1'b1,
                         res_t'{1'b1, 6'd0, 32'h0, 32'hFFFF_FFFF}});
    dir_rows.push_back('{FUNC_READ, 32'h0, 32'h0, 6'd3, 1'b0, 1'b1,
                         res_t'{1'b1, 6'd3, 32'hFFFF_FFFF, 32'h0}});
    dir_rows.push_back('{FUNC_READ, 32'h0, 32'h0, 6'd4, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_LOOKUP, 32'h8000_0000, 32'h0, 6'd0, 1'b0, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0, 6'd0, 1'b1, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOOKUP, 32'h0, 32'h0, 6'd0, 1'b0, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOOKUP, 32'h0000_0001, 32'h0, 6'd0, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0, 6'd0, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOAD, 32'h5, 32'h50, 6'd0, 1'b1, 1'b0, MISS});
    dir_rows.push_back('{FUNC_LOOKUP, 32'h5, 32'h0, 6'd0, 1'b0, 1'b1,
                         res_t'{1'b1, 6'd0, 32'h5, 32'h50}});
    dir_rows.push_back('{FUNC_READ, 32'h0, 32'h0, 6'd1, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_LOOKUP, 32'h4, 32'h0, 6'd0, 1'b0, 1'b1, MISS});
    dir_rows.push_back('{FUNC_READ, 32'hDEAD_BEEF, 32'hCAFE_F00D, 6'd63, 1'b0, 1'b1, MISS});

    // Hold reset, then release it once
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      rq = '{dir_rows[i].func, dir_rows[i].key, dir_rows[i].payload,
             dir_rows[i].position, dir_rows[i].last};
      send_req(rq, dir_rows[i].typed, dir_rows[i].exp);
    end

    // Random part: well-formed sets of distinct keys closed by a last load, each followed
    // by lookups and reads; noise transactions are mixed into the loads
    while (items_sent < NUM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 5) set_size = $urandom_range(DEPTH, DEPTH + 6);   // fill and overflow
      else if (r < 15) set_size = $urandom_range(17, DEPTH - 1);
      else set_size = $urandom_range(1, 16);
      set_keys.delete();
      for (int unsigned j = 0; j < set_size; j++) begin
        if ($urandom_range(0, 99) < 10) begin
          noise.func     = 2'($urandom_range(1, 3));
          noise.key      = $urandom();
          noise.payload  = $urandom();
          noise.position = 6'($urandom_range(0, 63));
          noise.last     = 1'($urandom_range(0, 1));
          send_req(noise, 1'b0, MISS);
        end
        // keep keys distinct within the set
        do begin
          k = $urandom();
          if ($urandom_range(0, 15) == 0) k = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          dup = 1'b0;
          foreach (set_keys[m]) if (set_keys[m] == k) dup = 1'b1;
        end while (dup);
        set_keys.push_back(k);
        rq.func     = FUNC_LOAD;
        rq.key      = k;
        rq.payload  = $urandom();
        rq.position = 6'($urandom_range(0, 63));
        rq.last     = (j == set_size - 1);
        send_req(rq, 1'b0, MISS);
      end
      lookups = $urandom_range(1, set_size + 6);
      if (lookups > 24) lookups = 24;
      for (int unsigned j = 0; j < lookups; j++) begin
        r = $urandom_range(0, 99);
        rq.key      = $urandom();
        rq.payload  = $urandom();
        rq.position = 6'($urandom_range(0, 63));
        rq.last     = 1'($urandom_range(0, 1));
        if (r < 45) begin
          rq.func = FUNC_LOOKUP;
          rq.key  = sorted_key[$urandom_range(0, fill_count - 1)];
        end else if (r < 65) begin
          rq.func = FUNC_LOOKUP;
          // probe just beside a stored key now and then
          if ($urandom_range(0, 1)) rq.key = sorted_key[$urandom_range(0, fill_count - 1)] + 1;
        end else if (r < 90) begin
          rq.func = FUNC_READ;
          if ($urandom_range(0, 9) < 7) rq.position = 6'($urandom_range(0, fill_count - 1));
        end else begin
          rq.func = FUNC_UNUSED;
        end
        send_req(rq, 1'b0, MISS);
      end
    end

    // Drop valid, drain the owed responses, then allow the tail latency
    s_valid <= 1'b0;
    quiet = 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && resp_q.size() == 0) begin
      $display("heap_sort_binary_search_table regression: pass");
    end else begin
      $display("heap_sort_binary_search_table regression: fail");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #6000000;
    $display("heap_sort_binary_search_table regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/hsbst_pkg.sv
hdl/hsbst_ram.sv
hdl/hsbst_ctrl.sv
hdl/heap_sort_binary_search_table.sv
hdl/hsbst_chk.sv
tb/heap_sort_binary_search_table_tb.sv
